[src/cfmv_pkg.sv]
// Shared constants for the cascaded FM voice: register map, reset values,
// default sizes and the quarter-wave sine generator used to build its table.
// No dependencies.
package cfmv_pkg;

  // Default sizes
  localparam int unsigned PHASE_BITS_DEF      = 24;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 24;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CARRIER_INCR    = 8'd0,
    REG_MODULATOR_RATIO = 8'd1,
    REG_CASC_RATIO      = 8'd2,
    REG_NOISE_STEP      = 8'd3
  } reg_index_t;

  // Register reset values
  localparam logic [23:0] CARRIER_INCR_RST    = 24'd167390;
  localparam logic [15:0] MODULATOR_RATIO_RST = 16'd13984;
  localparam logic [15:0] CASC_RATIO_RST      = 16'd34918;
  localparam logic [23:0] NOISE_STEP_RST      = 24'd2663050;

  // Q30 coefficients of the odd quarter-wave polynomial
  localparam longint unsigned K_C1 = 64'd1686629713;
  localparam longint unsigned K_C3 = 64'd693598668;
  localparam longint unsigned K_C5 = 64'd85569306;
  localparam longint unsigned K_C7 = 64'd5026994;
  localparam longint unsigned K_C9 = 64'd172273;

  // Quarter-wave magnitude in unsigned Q0.15 for one table step; evaluated at elaboration
  function automatic logic [14:0] quarter_sine(input int unsigned frac,
                                               input int unsigned fbits);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned q;
    z  = longint'(frac) << (30 - fbits);
    z2 = (z * z) >> 30;
    p  = K_C9;
    p  = K_C7 - ((z2 * p) >> 30);
    p  = K_C5 - ((z2 * p) >> 30);
    p  = K_C3 - ((z2 * p) >> 30);
    p  = K_C1 - ((z2 * p) >> 30);
    s  = (z * p) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

endpackage

[src/cascaded_fm_voice.sv]
// Cascaded three-operator FM voice: noise sample-and-hold, three phase
// accumulators, sine table lookups and amplitude scaling in one pipeline.
// Depends on cfmv_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_ready   | glide_step amp_level index_depth
//           |                       | cascade_depth noise_depth noise_draw
//  output   | out_valid / out_ready | sample_out
//  config   | cfg_valid / cfg_ready | cfg_index cfg_data (cfg_ready always high)
//
// One request per cycle sustained while out_ready is high; a request passes the
// stage 1, 2, 3 and output registers before its sample appears. The per-cycle
// bound is the phase stage: sine table read, depth multiply and three-input add
// feeding back into the phase registers. Reset clears phases, noise state and
// all valid bits and restores the register defaults. A stalled output holds the
// pipeline; in_ready falls only when all four stages are occupied.
module cascaded_fm_voice #(
  parameter int unsigned PHASE_BITS      = cfmv_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = cfmv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input request
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [15:0]                      glide_step,
  input  logic [15:0]                      amp_level,
  input  logic [23:0]                      index_depth,
  input  logic [23:0]                      cascade_depth,
  input  logic [22:0]                      noise_depth,
  input  logic signed [15:0]               noise_draw,
  // output request
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               sample_out,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfmv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfmv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned FBITS = SINE_TABLE_BITS - 2;
  localparam int unsigned QN    = 1 << FBITS;
  localparam logic [14:0] SINE_TOP = cfmv_pkg::quarter_sine(QN, FBITS);

  // Configuration registers
  logic [23:0] carrier_incr;
  logic [15:0] modulator_ratio;
  logic [15:0] casc_ratio;
  logic [23:0] noise_step;

  // Voice state
  logic [PB-1:0]      carrier_phase;
  logic [PB-1:0]      modulator_phase;
  logic [PB-1:0]      cascade_phase;
  logic [23:0]        noise_accum;
  logic signed [15:0] noise_hold;
  logic               started;

  // Pipeline valid bits
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;

  // Stage payloads
  logic [24:0]        s1_base;
  logic [15:0]        s1_amp;
  logic [23:0]        s1_idx_depth;
  logic [23:0]        s1_cas_depth;
  logic [22:0]        s1_nz_depth;
  logic signed [15:0] s1_hold;

  logic [PB-1:0]      s2_cas_inc;
  logic [PB-1:0]      s2_mod_inc;
  logic [PB-1:0]      s2_noise_off;
  logic [PB-1:0]      s2_base_ph;
  logic [15:0]        s2_amp;
  logic [23:0]        s2_idx_depth;
  logic [23:0]        s2_cas_depth;

  logic signed [15:0] s3_sine;
  logic [15:0]        s3_amp;

  // Flow control
  logic in_accept;
  logic out_free;
  logic s3_free;
  logic s2_free;
  logic s1_free;
  logic s2_adv;
  logic s1_adv;

  assign out_free  = !out_valid || out_ready;
  assign s3_free   = !s3_valid || out_free;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign s2_adv    = s2_valid && s3_free;
  assign s1_adv    = s1_valid && s2_free;
  assign in_ready  = s1_free;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_incr    <= cfmv_pkg::CARRIER_INCR_RST;
      modulator_ratio <= cfmv_pkg::MODULATOR_RATIO_RST;
      casc_ratio      <= cfmv_pkg::CASC_RATIO_RST;
      noise_step      <= cfmv_pkg::NOISE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfmv_pkg::REG_CARRIER_INCR:    carrier_incr    <= cfg_data[23:0];
        cfmv_pkg::REG_MODULATOR_RATIO: modulator_ratio <= cfg_data[15:0];
        cfmv_pkg::REG_CASC_RATIO:      casc_ratio      <= cfg_data[15:0];
        cfmv_pkg::REG_NOISE_STEP:      noise_step      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Noise rate accumulator; reload the hold on carry or on the first request
  logic [24:0]        noise_sum;
  logic signed [15:0] noise_hold_next;

  always_comb begin
    noise_sum       = {1'b0, noise_accum} + {1'b0, noise_step};
    noise_hold_next = (noise_sum[24] || !started) ? noise_draw : noise_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_accum <= '0;
      noise_hold  <= '0;
      started     <= 1'b0;
    end else if (in_accept) begin
      noise_accum <= noise_sum[23:0];
      noise_hold  <= noise_hold_next;
      started     <= 1'b1;
    end
  end

  // Stage 1: capture the request with its base step and held noise value
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_base      <= {1'b0, carrier_incr} + {9'd0, glide_step};
      s1_amp       <= amp_level;
      s1_idx_depth <= index_depth;
      s1_cas_depth <= cascade_depth;
      s1_nz_depth  <= noise_depth;
      s1_hold      <= noise_hold_next;
    end
  end

  // Stage 2: ratio-scaled steps and noise deviation
  logic [40:0]        cas_prod;
  logic [40:0]        mod_prod;
  logic signed [38:0] nz_prod;
  logic [PB+28:0]     cas_ext;
  logic [PB+28:0]     mod_ext;
  logic [PB+23:0]     nz_ext;
  logic [PB+24:0]     base_ext;

  always_comb begin
    cas_prod = s1_base * casc_ratio;
    mod_prod = s1_base * modulator_ratio;
    nz_prod  = $signed({1'b0, s1_nz_depth}) * s1_hold;
    cas_ext  = {{PB{1'b0}}, cas_prod[40:12]};
    mod_ext  = {{PB{1'b0}}, mod_prod[40:12]};
    nz_ext   = {{PB{nz_prod[38]}}, nz_prod[38:15]};
    base_ext = {{PB{1'b0}}, s1_base};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_cas_inc   <= cas_ext[PB-1:0];
      s2_mod_inc   <= mod_ext[PB-1:0];
      s2_noise_off <= nz_ext[PB-1:0];
      s2_base_ph   <= base_ext[PB-1:0];
      s2_amp       <= s1_amp;
      s2_idx_depth <= s1_idx_depth;
      s2_cas_depth <= s1_cas_depth;
    end
  end

  // Quarter-wave table, built at elaboration
  logic [14:0] quarter [QN];

  for (genvar i = 0; i < QN; i++) begin : g_table
    assign quarter[i] = cfmv_pkg::quarter_sine(i, FBITS);
  end

  // Sine lookups on the current phases: cascade, modulator, carrier
  logic [PB-1:0]      lane_phase [3];
  logic signed [15:0] lane_sine  [3];

  assign lane_phase[0] = cascade_phase;
  assign lane_phase[1] = modulator_phase;
  assign lane_phase[2] = carrier_phase;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]                 quad;
    logic [FBITS-1:0]           frac;
    logic [FBITS-1:0]           addr;
    logic [14:0]                mag;

    always_comb begin
      k    = lane_phase[l][PB-1 -: SINE_TABLE_BITS];
      quad = k[SINE_TABLE_BITS-1 -: 2];
      frac = k[FBITS-1:0];
      // mirror odd quadrants; a zero fraction there is the quarter-wave peak
      addr = quad[0] ? (~frac + 1'b1) : frac;
      mag  = (quad[0] && (frac == '0)) ? SINE_TOP : quarter[addr];
      lane_sine[l] = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // Stage 3: modulation offsets and phase advance
  logic signed [40:0] mod_off_prod;
  logic signed [40:0] car_off_prod;
  logic [PB+25:0]     mod_off_ext;
  logic [PB+25:0]     car_off_ext;

  always_comb begin
    mod_off_prod = $signed({1'b0, s2_cas_depth}) * lane_sine[0];
    car_off_prod = $signed({1'b0, s2_idx_depth}) * lane_sine[1];
    mod_off_ext  = {{PB{mod_off_prod[40]}}, mod_off_prod[40:15]};
    car_off_ext  = {{PB{car_off_prod[40]}}, car_off_prod[40:15]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid        <= 1'b0;
      cascade_phase   <= '0;
      modulator_phase <= '0;
      carrier_phase   <= '0;
    end else begin
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (s2_adv) begin
        cascade_phase   <= cascade_phase + s2_cas_inc + s2_noise_off;
        modulator_phase <= modulator_phase + s2_mod_inc + mod_off_ext[PB-1:0];
        carrier_phase   <= carrier_phase + s2_base_ph + car_off_ext[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_sine <= lane_sine[2];
      s3_amp  <= s2_amp;
    end
  end

  // Output stage: scale carrier sine by amplitude
  logic signed [32:0] out_prod;

  assign out_prod = s3_sine * $signed({1'b0, s3_amp});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && out_free) begin
      sample_out <= out_prod[31:16];
    end
  end

`ifndef ASSERT_OFF
  // First request after reset loads the held noise from its draw
  a_first_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !started |=> noise_hold == $past(noise_draw))
    else $error("noise hold not loaded on first request");

  // Input backpressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && s3_valid && out_valid)
    else $error("input stalled with a free stage");

  // Phases move only when an item enters the phase stage
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !s2_adv |=> $stable(carrier_phase) && $stable(modulator_phase)
                && $stable(cascade_phase))
    else $error("phase changed without an item");
`endif

endmodule

[sim/tb_cascaded_fm_voice.sv]
// Self-checking testbench for cascaded_fm_voice: streams voice requests and
// register writes, predicts every output sample and compares it in order.
// Depends on cfmv_pkg and cascaded_fm_voice.
module tb_cascaded_fm_voice;

  localparam int PB  = cfmv_pkg::PHASE_BITS_DEF;
  localparam int STB = cfmv_pkg::SINE_TABLE_BITS_DEF;

  // Register indexes outside the map, written to check they are ignored
  localparam logic [cfmv_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED       = 8'hFF;
  localparam logic [cfmv_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNMAPPED = 8'd4;

  // Q30 quarter-wave polynomial coefficients
  localparam longint unsigned Q30_C1 = 64'd1686629713;
  localparam longint unsigned Q30_C3 = 64'd693598668;
  localparam longint unsigned Q30_C5 = 64'd85569306;
  localparam longint unsigned Q30_C7 = 64'd5026994;
  localparam longint unsigned Q30_C9 = 64'd172273;

  typedef struct packed {
    logic [15:0] glide;
    logic [15:0] amp;
    logic [23:0] index_d;
    logic [23:0] casc_d;
    logic [22:0] noise_d;
    logic [15:0] draw;
  } voice_req_t;

  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             in_valid      = 1'b0;
  logic                             in_ready;
  logic [15:0]                      glide_step    = '0;
  logic [15:0]                      amp_level     = '0;
  logic [23:0]                      index_depth   = '0;
  logic [23:0]                      cascade_depth = '0;
  logic [22:0]                      noise_depth   = '0;
  logic signed [15:0]               noise_draw    = '0;
  logic                             out_valid;
  logic                             out_ready     = 1'b0;
  logic signed [15:0]               sample_out;
  logic                             cfg_valid     = 1'b0;
  logic                             cfg_ready;
  logic [cfmv_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [cfmv_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

  // No idling on either side while set
  logic calm = 1'b0;

  voice_req_t         voice_reqs[$];
  logic signed [15:0] expected_samples[$];
  voice_req_t         cur_req;
  logic signed [15:0] want;
  int unsigned        mismatches = 0;

  // Predicted registers and voice state
  logic [23:0] carrier_incr_r;
  logic [15:0] mod_ratio_r;
  logic [15:0] casc_ratio_r;
  logic [23:0] noise_step_r;
  logic [23:0] car_ph;
  logic [23:0] mod_ph;
  logic [23:0] casc_ph;
  logic [23:0] noise_acc;
  logic [15:0] noise_held;
  logic        noise_live;

  cascaded_fm_voice dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .glide_step   (glide_step),
    .amp_level    (amp_level),
    .index_depth  (index_depth),
    .cascade_depth(cascade_depth),
    .noise_depth  (noise_depth),
    .noise_draw   (noise_draw),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sine of a phase, Q1.15, from the top table bits with quarter-wave mirroring
  function automatic logic signed [15:0] phase_to_sine(input logic [23:0] ph);
    logic [STB-1:0] k;
    longint unsigned frac, z, z2, p, s, q;
    k = ph[PB-1 -: STB];
    frac = k[STB-3:0];
    if (k[STB-2]) begin
      frac = (64'd1 << (STB - 2)) - frac;
    end
    z  = frac << (30 - (STB - 2));
    z2 = (z * z) >> 30;
    p  = Q30_C9;
    p  = Q30_C7 - ((z2 * p) >> 30);
    p  = Q30_C5 - ((z2 * p) >> 30);
    p  = Q30_C3 - ((z2 * p) >> 30);
    p  = Q30_C1 - ((z2 * p) >> 30);
    s  = (z * p) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return k[STB-1] ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  // Advance the voice by one request and return the sample it yields
  function automatic logic signed [15:0] voice_predict(input voice_req_t r);
    logic [24:0]        acc_sum;
    logic [24:0]        base;
    logic signed [15:0] s_casc, s_mod, s_car;
    longint unsigned    casc_inc, mod_inc;
    longint             a, b, nz_term, cd_term, id_term, scaled;
    acc_sum = {1'b0, noise_acc} + {1'b0, noise_step_r};
    noise_acc = acc_sum[23:0];
    // reload the held noise on a rate carry or on the first request
    if (acc_sum[24] || !noise_live) begin
      noise_held = r.draw;
      noise_live = 1'b1;
    end
    s_casc = phase_to_sine(casc_ph);
    s_mod  = phase_to_sine(mod_ph);
    s_car  = phase_to_sine(car_ph);
    base = carrier_incr_r + r.glide;
    casc_inc = base * casc_ratio_r;
    mod_inc  = base * mod_ratio_r;
    a = r.noise_d;
    b = $signed(noise_held);
    nz_term = (a * b) >>> 15;
    a = r.casc_d;
    b = s_casc;
    cd_term = (a * b) >>> 15;
    a = r.index_d;
    b = s_mod;
    id_term = (a * b) >>> 15;
    // phases wrap modulo 2^24
    casc_ph = casc_ph + casc_inc[35:12] + nz_term[23:0];
    mod_ph  = mod_ph + mod_inc[35:12] + cd_term[23:0];
    car_ph  = car_ph + base[23:0] + id_term[23:0];
    a = s_car;
    b = r.amp;
    scaled = (a * b) >>> 16;
    return scaled[15:0];
  endfunction

  // Pick an extreme or a random value of the given width
  function automatic logic [23:0] pick_val(input int w);
    logic [31:0] m;
    m = (32'd1 << w) - 32'd1;
    case ($urandom_range(7))
      0: return '0;
      1: return m[23:0];
      2: return 24'd1 << (w - 1);
      default: return 24'($urandom & m);
    endcase
  endfunction

  function automatic voice_req_t rand_req();
    voice_req_t r;
    r.glide   = 16'(pick_val(16));
    r.amp     = 16'(pick_val(16));
    r.index_d = pick_val(24);
    r.casc_d  = pick_val(24);
    r.noise_d = 23'(pick_val(23));
    r.draw    = 16'(pick_val(16));
    return r;
  endfunction

  function automatic voice_req_t mk_req(input logic [15:0] glide, input logic [15:0] amp,
                                        input logic [23:0] index_d, input logic [23:0] casc_d,
                                        input logic [22:0] noise_d, input logic [15:0] draw);
    voice_req_t r;
    r.glide   = glide;
    r.amp     = amp;
    r.index_d = index_d;
    r.casc_d  = casc_d;
    r.noise_d = noise_d;
    r.draw    = draw;
    return r;
  endfunction

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [cfmv_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cfmv_pkg::REG_CARRIER_INCR:    carrier_incr_r = val;
      cfmv_pkg::REG_MODULATOR_RATIO: mod_ratio_r    = val[15:0];
      cfmv_pkg::REG_CASC_RATIO:      casc_ratio_r   = val[15:0];
      cfmv_pkg::REG_NOISE_STEP:      noise_step_r   = val;
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every sample has come back
  task automatic drain();
    while (voice_reqs.size() != 0 || in_valid || expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: predict each accepted request, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(voice_predict(cur_req));
      end
      if (!in_valid || in_ready) begin
        if (voice_reqs.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          cur_req = voice_reqs.pop_front();
          glide_step    <= cur_req.glide;
          amp_level     <= cur_req.amp;
          index_depth   <= cur_req.index_d;
          cascade_depth <= cur_req.casc_d;
          noise_depth   <= cur_req.noise_d;
          noise_draw    <= cur_req.draw;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted sample with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample_out %0d arrived with no sample pending", $time, sample_out);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_out !== want) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want, sample_out);
            mismatches++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  initial begin
    voice_req_t r;
    voice_req_t tmpl;
    carrier_incr_r = cfmv_pkg::CARRIER_INCR_RST;
    mod_ratio_r    = cfmv_pkg::MODULATOR_RATIO_RST;
    casc_ratio_r   = cfmv_pkg::CASC_RATIO_RST;
    noise_step_r   = cfmv_pkg::NOISE_STEP_RST;
    car_ph     = '0;
    mod_ph     = '0;
    casc_ph    = '0;
    noise_acc  = '0;
    noise_held = '0;
    noise_live = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first request loads the noise, then run past a rate carry
    voice_reqs.push_back(mk_req(16'h0, 16'h0, 24'h0, 24'h0, 23'h0, 16'h7FFF));
    voice_reqs.push_back(mk_req(16'h0, 16'hFFFF, 24'h0, 24'h0, 23'h0, 16'h8000));
    voice_reqs.push_back(mk_req(16'hFFFF, 16'hFFFF, 24'h800000, 24'h800000,
                                23'h7FFFFF, 16'h8000));
    voice_reqs.push_back(mk_req(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                23'h7FFFFF, 16'h7FFF));
    for (int i = 0; i < 8; i++) begin
      voice_reqs.push_back(mk_req(16'(i * 8191), 16'hFFFF, 24'h400000, 24'h200000,
                                  23'h400000, i[0] ? 16'h8000 : 16'h7FFF));
    end

    // Out-of-range steps and ratios, noise refresh almost every sample
    drain();
    write_reg(cfmv_pkg::REG_CARRIER_INCR, 24'hFFFFFF);
    write_reg(cfmv_pkg::REG_MODULATOR_RATIO, 24'hFFFFFF);
    write_reg(cfmv_pkg::REG_CASC_RATIO, 24'hFFFFFF);
    write_reg(cfmv_pkg::REG_NOISE_STEP, 24'hFFFFFF);
    write_reg(REG_UNMAPPED, 24'h000000);
    for (int i = 0; i < 4; i++) begin
      voice_reqs.push_back(mk_req(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                  23'h7FFFFF, i[0] ? 16'h7FFF : 16'h8000));
    end
    voice_reqs.push_back(mk_req(16'hFFFF, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF, 16'h1));
    voice_reqs.push_back(mk_req(16'h0, 16'h8000, 24'h0, 24'h0, 23'h0, 16'h0));

    // All registers zero: phases hold unless glide or depth moves them
    drain();
    write_reg(cfmv_pkg::REG_CARRIER_INCR, 24'h0);
    write_reg(cfmv_pkg::REG_MODULATOR_RATIO, 24'h0);
    write_reg(cfmv_pkg::REG_CASC_RATIO, 24'h0);
    write_reg(cfmv_pkg::REG_NOISE_STEP, 24'h0);
    voice_reqs.push_back(mk_req(16'h0, 16'hFFFF, 24'h0, 24'h0, 23'h0, 16'h7FFF));
    voice_reqs.push_back(mk_req(16'h0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF, 16'h8000));
    voice_reqs.push_back(mk_req(16'hFFFF, 16'hFFFF, 24'h800000, 24'h800000, 23'h0, 16'h1));
    voice_reqs.push_back(mk_req(16'h1, 16'h1, 24'h1, 24'h1, 23'h1, 16'hFFFF));

    // Random notes: a held template per phase with amplitude and draw moving
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      calm <= (ph == 5);
      if ($urandom_range(1)) write_reg(cfmv_pkg::REG_CARRIER_INCR, pick_val(24));
      if ($urandom_range(1)) write_reg(cfmv_pkg::REG_MODULATOR_RATIO, pick_val(24));
      if ($urandom_range(1)) write_reg(cfmv_pkg::REG_CASC_RATIO, pick_val(24));
      if ($urandom_range(1)) write_reg(cfmv_pkg::REG_NOISE_STEP, pick_val(24));
      if ($urandom_range(3) == 0) begin
        write_reg(8'($urandom_range(255, REG_FIRST_UNMAPPED)), pick_val(24));
      end
      tmpl = rand_req();
      for (int n = 0; n < 112; n++) begin
        r = rand_req();
        if ($urandom_range(3) != 0) begin
          r.glide   = tmpl.glide;
          r.index_d = tmpl.index_d;
          r.casc_d  = tmpl.casc_d;
          r.noise_d = tmpl.noise_d;
        end
        voice_reqs.push_back(r);
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
